[sv/mset_pkg.sv]
// ----------------------------------------------------------------------------
// mset_pkg
// Shared types and codes for the multiset table engine.
// ----------------------------------------------------------------------------
package mset_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_QUERY  = 3'd1;
    localparam logic [2:0] OP_UNION  = 3'd2;
    localparam logic [2:0] OP_INTER  = 3'd3;
    localparam logic [2:0] OP_SUM    = 3'd4;
    localparam logic [2:0] OP_DIFF   = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]         opcode;
        logic               set_sel;
        logic signed [31:0] value;
        logic [15:0]        count;
    } item_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [15:0]        count_out;
        logic [5:0]         cardinality;
        logic               empty_res;
        logic               last;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        logic        app_en;
        logic        upd_en;
        logic [15:0] cnt;
    } tbl_ctl_t;

endpackage

[sv/mset_cell.sv]
// ----------------------------------------------------------------------------
// mset_cell
// One table entry: value and count, shifts from its neighbor on append.
// ----------------------------------------------------------------------------
module mset_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  shift_en,
    input  logic                  upd_en,
    input  logic [VALUE_BITS-1:0] prev_val,
    input  logic [15:0]           prev_cnt,
    input  logic [15:0]           upd_cnt,
    input  logic [VALUE_BITS-1:0] key,
    output logic [VALUE_BITS-1:0] val,
    output logic [15:0]           cnt,
    output logic                  hit
);
    logic [VALUE_BITS-1:0] val_reg;
    logic [15:0]           cnt_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            val_reg <= prev_val;
            cnt_reg <= prev_cnt;
        end
        else if (upd_en)
        begin
            cnt_reg <= upd_cnt;
        end
    end

    assign val = val_reg;
    assign cnt = cnt_reg;
    assign hit = (val_reg == key);
endmodule

[sv/mset_table.sv]
// ----------------------------------------------------------------------------
// mset_table
// Chain of entry cells with size, key search and read by insertion order.
// ----------------------------------------------------------------------------
module mset_table #(
    parameter int TABLE_DEPTH = 32,
    parameter int VALUE_BITS  = 32,
    parameter int SW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mset_pkg::tbl_ctl_t       ctl,
    input  logic [VALUE_BITS-1:0]    key,
    input  logic [SW-1:0]            rd_idx,
    output logic                     hit,
    output logic [15:0]              hit_cnt,
    output logic [VALUE_BITS-1:0]    rd_val,
    output logic [15:0]              rd_cnt,
    output logic [SW-1:0]            size
);
    import mset_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    logic [SW-1:0]         size_reg;
    logic [VALUE_BITS-1:0] cval [TABLE_DEPTH];
    logic [15:0]           ccnt [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] chit;
    logic [TABLE_DEPTH-1:0] cvalid;
    logic [SW-1:0]         rd_cell;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (ctl.app_en)
        begin
            size_reg <= size_reg + SW'(1);
        end
    end

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        logic [VALUE_BITS-1:0] pv;
        logic [15:0]           pc;
        if (k == 0)
        begin : g_head
            assign pv = key;
            assign pc = ctl.cnt;
        end
        else
        begin : g_body
            assign pv = cval[k-1];
            assign pc = ccnt[k-1];
        end
        assign cvalid[k] = (SW'(k) < size_reg);
        mset_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
            .clk      (clk),
            .shift_en (ctl.app_en),
            .upd_en   (ctl.upd_en & chit[k] & cvalid[k]),
            .prev_val (pv),
            .prev_cnt (pc),
            .upd_cnt  (ctl.cnt),
            .key      (key),
            .val      (cval[k]),
            .cnt      (ccnt[k]),
            .hit      (chit[k])
        );
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_cnt = '0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            if (chit[k] && cvalid[k])
            begin
                hit     = 1'b1;
                hit_cnt = hit_cnt | ccnt[k];
            end
        end
    end

    // insertion index i sits in cell size-1-i
    assign rd_cell = size_reg - SW'(1) - rd_idx;
    assign rd_val  = cval[rd_cell[IW-1:0]];
    assign rd_cnt  = ccnt[rd_cell[IW-1:0]];
    assign size    = size_reg;
endmodule

[sv/multiset_table_engine_top.sv]
// ----------------------------------------------------------------------------
// multiset_table_engine_top
// Two multiset tables with insert, query and union/inter/sum/diff runs.
//
//  channel  | ports                        | handshake
//  ---------+------------------------------+---------------------------------
//  command  | start, busy, item            | taken when start & !busy
//  result   | result_strobe, result        | one-cycle strobe per item, no stall
//
//  Insert/query: command registered, then executed; one result item.
//  Set op: walks table A, then table B for union/sum, one entry per cycle
//  through the cell chain search; results lag one entry so last is known.
//  Reset empties both tables; stored entries are not cleared.
// ----------------------------------------------------------------------------
module multiset_table_engine_top #(
    parameter int TABLE_DEPTH = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mset_pkg::item_t     item,
    output logic                result_strobe,
    output mset_pkg::result_t   result
);
    import mset_pkg::*;

    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int VB = VALUE_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_WALKA = 3'd2;
    localparam logic [2:0] S_WALKB = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]    state_reg, state_next;
    item_t         cmd_reg;
    logic [SW-1:0] idx_reg, idx_next;
    result_t       pend_reg, pend_next;
    logic          pend_vld_reg, pend_vld_next;
    result_t       res_reg, res_next;
    logic          strobe_reg, strobe_next;

    logic [VB-1:0] cmd_key, a_key, b_key;
    tbl_ctl_t      a_ctl, b_ctl;
    logic          a_hit, b_hit;
    logic [15:0]   a_hcnt, b_hcnt, a_rcnt, b_rcnt;
    logic [VB-1:0] a_rval, b_rval;
    logic [SW-1:0] a_size, b_size;

    function automatic logic signed [31:0] to_out(input logic [VB-1:0] v);
        logic [63:0] w;
        w = {{(64-VB){v[VB-1]}}, v};
        if (VB >= 32)
        begin
            w = 64'(v);
        end
        return w[31:0];
    endfunction

    if (VB == 32)
    begin : g_k32
        assign cmd_key = cmd_reg.value;
    end
    else if (VB > 32)
    begin : g_kwide
        assign cmd_key = {{(VB-32){1'b0}}, cmd_reg.value};
    end
    else
    begin : g_knarrow
        assign cmd_key = cmd_reg.value[VB-1:0];
    end

    mset_table #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VB)) u_tbl_a (
        .clk(clk), .rst_n(rst_n), .ctl(a_ctl), .key(a_key), .rd_idx(idx_reg),
        .hit(a_hit), .hit_cnt(a_hcnt), .rd_val(a_rval), .rd_cnt(a_rcnt),
        .size(a_size)
    );

    mset_table #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VB)) u_tbl_b (
        .clk(clk), .rst_n(rst_n), .ctl(b_ctl), .key(b_key), .rd_idx(idx_reg),
        .hit(b_hit), .hit_cnt(b_hcnt), .rd_val(b_rval), .rd_cnt(b_rcnt),
        .size(b_size)
    );

    assign a_key = (state_reg == S_WALKB) ? b_rval : cmd_key;
    assign b_key = (state_reg == S_WALKA) ? a_rval : cmd_key;

    logic          s_hit;
    logic [15:0]   s_hcnt;
    logic [SW-1:0] s_size;
    logic [16:0]   ins_sum;
    logic [16:0]   op_sum;
    logic [15:0]   r_cnt;
    logic [1:0]    r_st;
    logic          produce;
    result_t       new_item;

    assign s_hit   = cmd_reg.set_sel ? b_hit : a_hit;
    assign s_hcnt  = cmd_reg.set_sel ? b_hcnt : a_hcnt;
    assign s_size  = cmd_reg.set_sel ? b_size : a_size;
    assign ins_sum = {1'b0, s_hcnt} + {1'b0, cmd_reg.count};
    assign op_sum  = {1'b0, a_rcnt} + {1'b0, b_hcnt};

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        res_next      = res_reg;
        strobe_next   = 1'b0;
        a_ctl         = '0;
        b_ctl         = '0;
        r_cnt         = '0;
        r_st          = ST_OK;
        produce       = 1'b0;
        new_item      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next      = '0;
                    pend_vld_next = 1'b0;
                    if (item.opcode == OP_INSERT || item.opcode == OP_QUERY)
                    begin
                        state_next = S_EXEC;
                    end
                    else if (item.opcode <= OP_DIFF)
                    begin
                        state_next = S_WALKA;
                    end
                end
            end
            S_EXEC:
            begin
                tbl_ctl_t c;
                logic [SW-1:0] sz;
                c     = '0;
                sz    = s_size;
                r_cnt = s_hcnt;
                if (cmd_reg.opcode == OP_INSERT && cmd_reg.count != '0)
                begin
                    if (s_hit)
                    begin
                        c.upd_en = 1'b1;
                        if (ins_sum[16])
                        begin
                            r_cnt = COUNT_MAX;
                            r_st  = ST_SAT;
                        end
                        else
                        begin
                            r_cnt = ins_sum[15:0];
                        end
                    end
                    else if (s_size >= SW'(TABLE_DEPTH))
                    begin
                        r_cnt = '0;
                        r_st  = ST_FULL;
                    end
                    else
                    begin
                        c.app_en = 1'b1;
                        r_cnt    = cmd_reg.count;
                        sz       = s_size + SW'(1);
                    end
                end
                c.cnt = r_cnt;
                if (cmd_reg.set_sel)
                begin
                    b_ctl = c;
                end
                else
                begin
                    a_ctl = c;
                end
                res_next.value_out   = to_out(cmd_key);
                res_next.count_out   = r_cnt;
                res_next.cardinality = 6'(sz);
                res_next.empty_res   = 1'b0;
                res_next.last        = 1'b1;
                res_next.status      = r_st;
                strobe_next          = 1'b1;
                state_next           = S_IDLE;
            end
            S_WALKA:
            begin
                if (idx_reg < a_size)
                begin
                    case (cmd_reg.opcode)
                        OP_UNION: r_cnt = (a_rcnt > b_hcnt) ? a_rcnt : b_hcnt;
                        OP_INTER: r_cnt = (a_rcnt < b_hcnt) ? a_rcnt : b_hcnt;
                        OP_SUM:
                        begin
                            if (op_sum[16])
                            begin
                                r_cnt = COUNT_MAX;
                                r_st  = ST_SAT;
                            end
                            else
                            begin
                                r_cnt = op_sum[15:0];
                            end
                        end
                        default: r_cnt = (a_rcnt > b_hcnt) ? a_rcnt - b_hcnt : '0;
                    endcase
                    produce            = (r_cnt != '0);
                    new_item.value_out = to_out(a_rval);
                    new_item.count_out = r_cnt;
                    new_item.status    = r_st;
                    idx_next           = idx_reg + SW'(1);
                end
                else
                begin
                    idx_next = '0;
                    if (cmd_reg.opcode == OP_UNION || cmd_reg.opcode == OP_SUM)
                    begin
                        state_next = S_WALKB;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_WALKB:
            begin
                if (idx_reg < b_size)
                begin
                    produce            = !a_hit && (b_rcnt != '0);
                    new_item.value_out = to_out(b_rval);
                    new_item.count_out = b_rcnt;
                    idx_next           = idx_reg + SW'(1);
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (pend_vld_reg)
                begin
                    res_next      = pend_reg;
                    res_next.last = 1'b1;
                end
                else
                begin
                    res_next           = '0;
                    res_next.empty_res = 1'b1;
                    res_next.last      = 1'b1;
                end
                strobe_next   = 1'b1;
                pend_vld_next = 1'b0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (produce)
        begin
            if (pend_vld_reg)
            begin
                res_next    = pend_reg;
                strobe_next = 1'b1;
            end
            pend_next     = new_item;
            pend_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        res_reg  <= res_next;
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= item;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = res_reg;
endmodule
